// ===== design/rgb_to_hsl_color_window_match_defines.svh =====
// assertion macros for the colour window match design
// no dependencies; taken in by include where assertions are written
`ifndef RGB_TO_HSL_COLOR_WINDOW_MATCH_DEFINES_SVH
`define RGB_TO_HSL_COLOR_WINDOW_MATCH_DEFINES_SVH

// condition holds at every clock edge outside reset
`define RHCW_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define RHCW_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define RHCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/rhcw_pkg.sv =====
// types, constants and helper functions for the colour window match
// no dependencies; imported by every module of the design
`timescale 1ns / 1ps

package rhcw_pkg;

   localparam int COMP_W       = 8;
   localparam int SUM_W        = 9;
   localparam int NUM_W        = 16;
   localparam int DEN_W        = 9;
   localparam int QUOT_W       = 8;
   localparam int PROD_W       = 24;
   localparam int FRONT_STAGES = 2;
   localparam int PIPE_STAGES  = FRONT_STAGES + QUOT_W + 1;
   localparam int REG_IDX_W    = 3;

   localparam logic [REG_IDX_W-1:0] REG_HUE_LOW    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_HUE_HIGH   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SAT_LOW    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SAT_HIGH   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_LIGHT_LOW  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_LIGHT_HIGH = 3'd5;

   localparam logic [COMP_W-1:0] HUE_LOW_RST    = 8'd130;
   localparam logic [COMP_W-1:0] HUE_HIGH_RST   = 8'd190;
   localparam logic [COMP_W-1:0] SAT_LOW_RST    = 8'd90;
   localparam logic [COMP_W-1:0] SAT_HIGH_RST   = 8'd240;
   localparam logic [COMP_W-1:0] LIGHT_LOW_RST  = 8'd50;
   localparam logic [COMP_W-1:0] LIGHT_HIGH_RST = 8'd160;

   localparam logic [COMP_W-1:0] SCALE_MAX   = 8'd240;
   localparam logic [COMP_W-1:0] HUE_STEP    = 8'd40;
   localparam logic [COMP_W-1:0] OFS_GREEN   = 8'd80;
   localparam logic [COMP_W-1:0] OFS_BLUE    = 8'd160;
   localparam logic [SUM_W-1:0]  SUM_FOLD    = 9'd511;
   localparam logic [SUM_W-1:0]  SUM_LOW_MAX = 9'd257;
   localparam logic [SUM_W-1:0]  SUM_DARK    = 9'd2;
   localparam logic [11:0]       RECIP_17    = 12'd3855;
   localparam logic [11:0]       DIV_17      = 12'd17;

   typedef enum logic [1:0] {
      HUE_RED_POS,
      HUE_RED_NEG,
      HUE_GREEN,
      HUE_BLUE
   } hue_sector_type;

   typedef struct packed {
      logic [NUM_W-1:0]  hue_num;
      logic [DEN_W-1:0]  hue_den;
      logic [NUM_W-1:0]  sat_num;
      logic [DEN_W-1:0]  sat_den;
      logic [SUM_W-1:0]  sum;
      logic [PROD_W-1:0] light_prod;
      logic              hue_neg;
      hue_sector_type    sector;
      logic              grey;
      logic              sat_zero;
   } front_out_type;

   typedef struct packed {
      logic [COMP_W-1:0] light;
      logic              hue_neg;
      hue_sector_type    sector;
      logic              grey;
      logic              sat_zero;
   } side_type;

   typedef struct packed {
      logic             qbit;
      logic [NUM_W-1:0] rem;
   } div_step_type;

   // one restoring division step against the divisor shifted left
   function automatic div_step_type div_step(input logic [NUM_W-1:0] rem,
                                             input logic [DEN_W-1:0] den,
                                             input int shift);
      logic [NUM_W+DEN_W-1:0] trial;
      logic [NUM_W+DEN_W-1:0] wide_rem;
      div_step_type           res;
      trial    = {{NUM_W{1'b0}}, den} << shift;
      wide_rem = {{DEN_W{1'b0}}, rem};
      if (wide_rem >= trial) begin
         res.qbit = 1'b1;
         res.rem  = rem - trial[NUM_W-1:0];
      end else begin
         res.qbit = 1'b0;
         res.rem  = rem;
      end
      return res;
   endfunction

endpackage

// ===== design/rgb_to_hsl_color_window_match.sv =====
// top level: rgb to hue/lightness/saturation with colour window match
// depends on rhcw_pkg, rhcw_front, rhcw_div and the assertion macros
//
//   channel | dir | fields (low bit first)
//   req     | in  | tdata: red, green, blue
//   rsp     | out | tdata: hue, lightness, saturation; tuser: in_window
//   csr     | in  | six 8-bit window bounds, indexes 0..5
//
// one item a cycle while the output is not stalled; two front stages, eight divider
// stages (one quotient bit each) and the output register
// reset clears valid bits and loads the window bounds, no clearing pass
// a stalled output freezes the whole pipeline; req_tready follows it
`timescale 1ns / 1ps
`include "rgb_to_hsl_color_window_match_defines.svh"

module rgb_to_hsl_color_window_match (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,   // red, green, blue
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [23:0]                       rsp_tdata,   // hue, lightness, saturation
   output logic                              rsp_tuser,   // in_window
   input  logic                              csr_we,
   input  logic [rhcw_pkg::REG_IDX_W-1:0]    csr_addr,
   input  logic [rhcw_pkg::COMP_W-1:0]       csr_wdata
);
   import rhcw_pkg::*;

   logic [COMP_W-1:0] hue_low_ff, hue_high_ff, sat_low_ff, sat_high_ff;
   logic [COMP_W-1:0] light_low_ff, light_high_ff;

   logic [PIPE_STAGES-1:0] vld_ff;
   logic                   adv;

   front_out_type     front_out;
   logic [QUOT_W-1:0] hue_quot, sat_quot;
   side_type          side_ff [QUOT_W];
   side_type          side_in;
   logic [11:0]       light_n, light_q0, light_r;

   logic [COMP_W-1:0] hue_ofs, hue_in, sat_in;
   logic [COMP_W-1:0] hue_ff, light_ff, sat_ff;
   logic              win_ff, win_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_low_ff    <= HUE_LOW_RST;
         hue_high_ff   <= HUE_HIGH_RST;
         sat_low_ff    <= SAT_LOW_RST;
         sat_high_ff   <= SAT_HIGH_RST;
         light_low_ff  <= LIGHT_LOW_RST;
         light_high_ff <= LIGHT_HIGH_RST;
      end else if (csr_we) begin
         case (csr_addr)
            REG_HUE_LOW:    hue_low_ff    <= csr_wdata;
            REG_HUE_HIGH:   hue_high_ff   <= csr_wdata;
            REG_SAT_LOW:    sat_low_ff    <= csr_wdata;
            REG_SAT_HIGH:   sat_high_ff   <= csr_wdata;
            REG_LIGHT_LOW:  light_low_ff  <= csr_wdata;
            REG_LIGHT_HIGH: light_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign adv        = !vld_ff[PIPE_STAGES-1] || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_STAGES-2:0], req_tvalid};
      end
   end

   rhcw_front u_front (
      .clock     (clock),
      .en        (adv),
      .red       (req_tdata[7:0]),
      .green     (req_tdata[15:8]),
      .blue      (req_tdata[23:16]),
      .front_out (front_out)
   );

   rhcw_div u_hue_div (
      .clock (clock),
      .en    (adv),
      .num   (front_out.hue_num),
      .den   (front_out.hue_den),
      .quot  (hue_quot)
   );

   rhcw_div u_sat_div (
      .clock (clock),
      .en    (adv),
      .num   (front_out.sat_num),
      .den   (front_out.sat_den),
      .quot  (sat_quot)
   );

   // lightness = sum*8/17 by reciprocal with one correction step
   always_comb begin
      light_n  = {front_out.sum, 3'b000};
      light_q0 = {4'b0000, front_out.light_prod[PROD_W-1:16]};
      light_r  = light_n - 12'(light_q0 * DIV_17);
      side_in.light    = (light_r >= DIV_17) ? light_q0[COMP_W-1:0] + 8'd1
                                             : light_q0[COMP_W-1:0];
      side_in.hue_neg  = front_out.hue_neg;
      side_in.sector   = front_out.sector;
      side_in.grey     = front_out.grey;
      side_in.sat_zero = front_out.sat_zero;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < QUOT_W; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   always_comb begin
      case (side_ff[QUOT_W-1].sector)
         HUE_RED_POS: hue_ofs = '0;
         HUE_RED_NEG: hue_ofs = SCALE_MAX;
         HUE_GREEN:   hue_ofs = OFS_GREEN;
         HUE_BLUE:    hue_ofs = OFS_BLUE;
         default:     hue_ofs = '0;
      endcase
      if (side_ff[QUOT_W-1].grey) begin
         hue_in = '0;
      end else if (side_ff[QUOT_W-1].hue_neg) begin
         hue_in = hue_ofs - hue_quot;
      end else begin
         hue_in = hue_ofs + hue_quot;
      end
      sat_in = side_ff[QUOT_W-1].sat_zero ? '0 : sat_quot;
      win_in = (hue_in > hue_low_ff) && (hue_in < hue_high_ff) &&
               (side_ff[QUOT_W-1].light > light_low_ff) &&
               (side_ff[QUOT_W-1].light < light_high_ff) &&
               (sat_in > sat_low_ff) && (sat_in < sat_high_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hue_ff   <= hue_in;
         light_ff <= side_ff[QUOT_W-1].light;
         sat_ff   <= sat_in;
         win_ff   <= win_in;
      end
   end

   assign rsp_tvalid = vld_ff[PIPE_STAGES-1];
   assign rsp_tdata  = {sat_ff, light_ff, hue_ff};
   assign rsp_tuser  = win_ff;

   `RHCW_ASSERT_IMPLY(a_hue_range, clock, reset, rsp_tvalid, hue_ff <= SCALE_MAX, "hue above 240")
   `RHCW_ASSERT_IMPLY(a_sat_range, clock, reset, rsp_tvalid, sat_ff <= SCALE_MAX, "saturation above 240")
   `RHCW_ASSERT_IMPLY(a_light_range, clock, reset, rsp_tvalid, light_ff <= SCALE_MAX, "lightness above 240")
   `RHCW_ASSERT_NEXT(a_stall_freeze, clock, reset, rsp_tvalid && !rsp_tready, vld_ff == $past(vld_ff), "pipeline moved while stalled")
   `RHCW_ASSERT_IMPLY(a_win_hue, clock, reset, rsp_tvalid && rsp_tuser, hue_ff > hue_low_ff && hue_ff < hue_high_ff, "match outside hue window")

endmodule

// ===== design/rhcw_front.sv =====
// front end: max/min sort, hue sector, then numerators and divisors
// depends on rhcw_pkg; two register stages advanced by en
`timescale 1ns / 1ps

module rhcw_front (
   input  logic                          clock,
   input  logic                          en,
   input  logic [rhcw_pkg::COMP_W-1:0]   red,
   input  logic [rhcw_pkg::COMP_W-1:0]   green,
   input  logic [rhcw_pkg::COMP_W-1:0]   blue,
   output rhcw_pkg::front_out_type       front_out
);
   import rhcw_pkg::*;

   logic [COMP_W-1:0] mx, mn, mag;
   logic [SUM_W-1:0]  diff;
   hue_sector_type    sector;

   logic [COMP_W-1:0] d_ff, mag_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic              neg_ff, grey_ff;
   hue_sector_type    sector_ff;
   front_out_type     out_ff, out_in;

   always_comb begin
      if (red >= green && red >= blue) begin
         mx = red;
         if (blue <= green) begin
            mn     = blue;
            sector = HUE_RED_POS;
         end else begin
            mn     = green;
            sector = HUE_RED_NEG;
         end
         diff = {1'b0, green} - {1'b0, blue};
      end else if (green >= blue) begin
         mx     = green;
         mn     = (red <= blue) ? red : blue;
         sector = HUE_GREEN;
         diff   = {1'b0, blue} - {1'b0, red};
      end else begin
         mx     = blue;
         mn     = (red <= green) ? red : green;
         sector = HUE_BLUE;
         diff   = {1'b0, red} - {1'b0, green};
      end
      mag = diff[SUM_W-1] ? COMP_W'(-diff) : diff[COMP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff      <= mx - mn;
         sum_ff    <= {1'b0, mx} + {1'b0, mn};
         mag_ff    <= mag;
         neg_ff    <= diff[SUM_W-1];
         sector_ff <= sector;
         grey_ff   <= (mx == mn);
      end
   end

   always_comb begin
      out_in.hue_num    = NUM_W'(mag_ff) * NUM_W'(HUE_STEP);
      out_in.hue_den    = {1'b0, d_ff};
      out_in.sat_num    = NUM_W'(d_ff) * NUM_W'(SCALE_MAX);
      out_in.sat_den    = (sum_ff <= SUM_LOW_MAX) ? sum_ff : SUM_FOLD - sum_ff;
      out_in.sum        = sum_ff;
      out_in.light_prod = PROD_W'({sum_ff, 3'b000}) * PROD_W'(RECIP_17);
      out_in.hue_neg    = neg_ff;
      out_in.sector     = sector_ff;
      out_in.grey       = grey_ff;
      out_in.sat_zero   = grey_ff | (sum_ff <= SUM_DARK);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign front_out = out_ff;

endmodule

// ===== design/rhcw_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on rhcw_pkg; QUOT_W register stages advanced by en
`timescale 1ns / 1ps

module rhcw_div (
   input  logic                        clock,
   input  logic                        en,
   input  logic [rhcw_pkg::NUM_W-1:0]  num,
   input  logic [rhcw_pkg::DEN_W-1:0]  den,
   output logic [rhcw_pkg::QUOT_W-1:0] quot
);
   import rhcw_pkg::*;

   logic [NUM_W-1:0]  rem_ff [QUOT_W];
   logic [DEN_W-1:0]  den_ff [QUOT_W];
   logic [QUOT_W-1:0] quo_ff [QUOT_W];
   logic [NUM_W-1:0]  rem_in [QUOT_W];
   logic [DEN_W-1:0]  den_in [QUOT_W];
   logic [QUOT_W-1:0] quo_in [QUOT_W];

   always_comb begin
      div_step_type step;
      for (int i = 0; i < QUOT_W; i++) begin
         if (i == 0) begin
            step      = div_step(num, den, QUOT_W - 1);
            den_in[i] = den;
            quo_in[i] = {{(QUOT_W-1){1'b0}}, step.qbit};
         end else begin
            step      = div_step(rem_ff[i-1], den_ff[i-1], QUOT_W - 1 - i);
            den_in[i] = den_ff[i-1];
            quo_in[i] = {quo_ff[i-1][QUOT_W-2:0], step.qbit};
         end
         rem_in[i] = step.rem;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < QUOT_W; i++) begin
            rem_ff[i] <= rem_in[i];
            den_ff[i] <= den_in[i];
            quo_ff[i] <= quo_in[i];
         end
      end
   end

   assign quot = quo_ff[QUOT_W-1];

endmodule
